FILE: rtl/isc_pkg.sv
// shared types, codes and reset values for the idle sleep tier controller
package isc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [1:0] tier_t;
    typedef logic [1:0] func_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam tier_t TIER_ACTIVE      = 2'd0;
    localparam tier_t TIER_DIM         = 2'd1;
    localparam tier_t TIER_SCREEN_OFF  = 2'd2;
    localparam tier_t TIER_LIGHT_SLEEP = 2'd3;

    localparam func_t FUNC_TICK     = 2'd0;
    localparam func_t FUNC_ACTIVITY = 2'd1;
    localparam func_t FUNC_RESTART  = 2'd2;

    localparam cfg_index_t CFG_LIGHT_SLEEP_ENABLE   = 3'd0;
    localparam cfg_index_t CFG_DIM_AFTER_MS         = 3'd1;
    localparam cfg_index_t CFG_SCREEN_OFF_AFTER_MS  = 3'd2;
    localparam cfg_index_t CFG_LIGHT_SLEEP_AFTER_MS = 3'd3;
    localparam cfg_index_t CFG_USER_SLEEP_DELAY_MS  = 3'd4;

    localparam logic  RST_LIGHT_SLEEP_ENABLE   = 1'b1;
    localparam time_t RST_DIM_AFTER_MS         = 32'd30000;
    localparam time_t RST_SCREEN_OFF_AFTER_MS  = 32'd60000;
    localparam time_t RST_LIGHT_SLEEP_AFTER_MS = 32'd300000;
    localparam time_t RST_USER_SLEEP_DELAY_MS  = 32'd5000;

endpackage

FILE: rtl/idle_sleep_tier_controller_top.sv
// idle sleep tier controller: input register, tier decision, result register
//
// Each accepted word (tick, activity note or restart with a millisecond
// timestamp) yields one result word with the power tier and a changed flag.
// A word sits in the input register, where the tier decision (two
// 32-bit wrapping subtractions and a few compares) runs against the policy
// state, and is then held in the result register until taken. One word is
// accepted per cycle as long as the result side keeps taking words; the result
// word is loaded into the result register when it leaves the input register,
// and is taken from there. A stalled result side holds at most two words, one
// in each register, before the input stalls. Configuration registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce; writes
// to indexes beyond the register list are ignored.
module idle_sleep_tier_controller_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  isc_pkg::cfg_index_t        cfg_index,
    input  logic [isc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  isc_pkg::func_t             func,
    input  isc_pkg::time_t             now_ms,
    input  logic                       busy_req,
    input  logic                       user_asleep,
    output logic                       out_valid,
    input  logic                       out_ready,
    output isc_pkg::tier_t             tier,
    output logic                       changed
);
    import isc_pkg::*;

    // configuration
    logic  light_sleep_enable_reg;
    time_t dim_after_ms_reg;
    time_t screen_off_after_ms_reg;
    time_t light_sleep_after_ms_reg;
    time_t user_sleep_delay_ms_reg;

    // policy state
    tier_t current_tier_reg, current_tier_next;
    logic  tier_changed_reg, tier_changed_next;
    time_t last_activity_reg, last_activity_next;
    time_t sleep_request_reg, sleep_request_next;
    logic  prior_asleep_reg, prior_asleep_next;

    // input register
    logic  a_valid_reg;
    func_t a_func_reg;
    time_t a_now_reg;
    logic  a_busy_reg;
    logic  a_asleep_reg;

    // result register
    logic  out_valid_reg;
    tier_t out_tier_reg;
    logic  out_changed_reg;

    logic  advance;
    time_t since_request;
    time_t idle_time;
    time_t request_time;
    tier_t tick_tier;

    assign advance  = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign tier      = out_tier_reg;
    assign changed   = out_changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_sleep_enable_reg   <= RST_LIGHT_SLEEP_ENABLE;
            dim_after_ms_reg         <= RST_DIM_AFTER_MS;
            screen_off_after_ms_reg  <= RST_SCREEN_OFF_AFTER_MS;
            light_sleep_after_ms_reg <= RST_LIGHT_SLEEP_AFTER_MS;
            user_sleep_delay_ms_reg  <= RST_USER_SLEEP_DELAY_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIGHT_SLEEP_ENABLE:   light_sleep_enable_reg   <= cfg_data[0];
                CFG_DIM_AFTER_MS:         dim_after_ms_reg         <= cfg_data;
                CFG_SCREEN_OFF_AFTER_MS:  screen_off_after_ms_reg  <= cfg_data;
                CFG_LIGHT_SLEEP_AFTER_MS: light_sleep_after_ms_reg <= cfg_data;
                CFG_USER_SLEEP_DELAY_MS:  user_sleep_delay_ms_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_func_reg   <= func;
            a_now_reg    <= now_ms;
            a_busy_reg   <= busy_req;
            a_asleep_reg <= user_asleep;
        end
    end

    // a fresh sleep request restarts the delay at this word's time
    assign request_time  = (a_asleep_reg && !prior_asleep_reg) ? a_now_reg
                                                               : sleep_request_reg;
    assign since_request = a_now_reg - request_time;
    assign idle_time     = a_now_reg - last_activity_reg;

    always_comb
    begin
        if (a_busy_reg)
        begin
            tick_tier = TIER_ACTIVE;
        end
        else if (a_asleep_reg)
        begin
            if (light_sleep_enable_reg && since_request >= user_sleep_delay_ms_reg)
                tick_tier = TIER_LIGHT_SLEEP;
            else
                tick_tier = TIER_SCREEN_OFF;
        end
        else if (light_sleep_enable_reg && idle_time >= light_sleep_after_ms_reg)
        begin
            tick_tier = TIER_LIGHT_SLEEP;
        end
        else if (idle_time >= screen_off_after_ms_reg)
        begin
            tick_tier = TIER_SCREEN_OFF;
        end
        else if (idle_time >= dim_after_ms_reg)
        begin
            tick_tier = TIER_DIM;
        end
        else
        begin
            tick_tier = TIER_ACTIVE;
        end
    end

    always_comb
    begin
        current_tier_next  = current_tier_reg;
        tier_changed_next  = tier_changed_reg;
        last_activity_next = last_activity_reg;
        sleep_request_next = sleep_request_reg;
        prior_asleep_next  = prior_asleep_reg;
        case (a_func_reg)
            FUNC_TICK:
            begin
                sleep_request_next = request_time;
                prior_asleep_next  = a_asleep_reg;
                if (a_busy_reg)
                    last_activity_next = a_now_reg;
                current_tier_next = tick_tier;
                tier_changed_next = (tick_tier != current_tier_reg);
            end
            FUNC_ACTIVITY:
            begin
                last_activity_next = a_now_reg;
            end
            FUNC_RESTART:
            begin
                current_tier_next  = TIER_ACTIVE;
                tier_changed_next  = 1'b1;
                last_activity_next = a_now_reg;
                sleep_request_next = a_now_reg;
                prior_asleep_next  = 1'b0;
            end
            default:
            begin
                current_tier_next = current_tier_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_tier_reg  <= TIER_ACTIVE;
            tier_changed_reg  <= 1'b1;
            last_activity_reg <= '0;
            sleep_request_reg <= '0;
            prior_asleep_reg  <= 1'b0;
        end
        else if (advance)
        begin
            current_tier_reg  <= current_tier_next;
            tier_changed_reg  <= tier_changed_next;
            last_activity_reg <= last_activity_next;
            sleep_request_reg <= sleep_request_next;
            prior_asleep_reg  <= prior_asleep_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_tier_reg    <= current_tier_next;
            out_changed_reg <= tier_changed_next;
        end
    end

endmodule

FILE: rtl/isc_checker.sv
// port-level checks for the idle sleep tier controller, bound to the top level
module isc_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  isc_pkg::tier_t      tier,
    input  logic                changed
);
    import isc_pkg::*;

    // words accepted but not yet delivered
    logic [1:0] pending_reg, pending_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
            pending_next = pending_reg + 2'd1;
        else if (!in_fire && out_fire)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tier) && $stable(changed))
        else $error("result word dropped or changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result word without an accepted input word");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more words in flight than the block holds");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && pending_reg == 2'd2)
        else $error("input stalled while the result side has room");

endmodule

bind idle_sleep_tier_controller_top isc_checker u_isc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tier      (tier),
    .changed   (changed)
);

FILE: sim/idle_sleep_tier_controller_top_tb.sv
`timescale 1ns / 100ps
// testbench for the idle sleep tier controller: random and directed words vs a tier predictor
module idle_sleep_tier_controller_top_tb;
    import isc_pkg::*;

    localparam func_t      FUNC_UNUSED      = 2'd3;
    localparam cfg_index_t CFG_UNUSED_INDEX = 3'd7;
    localparam int         DRAIN_EVERY      = 173;
    localparam int         MAX_PRINTED      = 100;

    typedef struct {
        func_t func;
        time_t now;
        logic  busy;
        logic  asleep;
    } policy_word_t;

    typedef struct {
        tier_t tier;
        logic  changed;
    } tier_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    func_t                 func = FUNC_TICK;
    time_t                 now_ms = '0;
    logic                  busy_req = 1'b0;
    logic                  user_asleep = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    tier_t                 tier;
    logic                  changed;

    idle_sleep_tier_controller_top dut (.*);

    always #10 clk = ~clk;

    // predicted policy registers and state
    logic  pol_ls_enable = RST_LIGHT_SLEEP_ENABLE;
    time_t pol_dim_ms = RST_DIM_AFTER_MS;
    time_t pol_screen_off_ms = RST_SCREEN_OFF_AFTER_MS;
    time_t pol_light_sleep_ms = RST_LIGHT_SLEEP_AFTER_MS;
    time_t pol_user_delay_ms = RST_USER_SLEEP_DELAY_MS;
    tier_t held_tier = TIER_ACTIVE;
    logic  held_changed = 1'b1;
    time_t last_activity_ms = '0;
    time_t sleep_request_ms = '0;
    logic  prior_asleep = 1'b0;

    policy_word_t pending_words[$];
    tier_word_t   expected_tiers[$];
    policy_word_t next_word;
    tier_word_t   want_word;
    int           mismatch_count = 0;
    int           launched_count = 0;
    int           send_idle_pct = 20;
    int           recv_idle_pct = 86;
    bit           word_taken = 1'b0;
    bit           drain_hold = 1'b0;
    time_t        clock_ms = '0;
    logic         asleep_now = 1'b0;

    function automatic tier_word_t next_tier_word(policy_word_t w);
        tier_word_t r;
        tier_t      prev;
        time_t      elapsed;
        case (w.func)
            FUNC_TICK:
            begin
                prev = held_tier;
                if (w.asleep && !prior_asleep)
                    sleep_request_ms = w.now;
                prior_asleep = w.asleep;
                if (w.busy)
                begin
                    last_activity_ms = w.now;
                    held_tier = TIER_ACTIVE;
                end
                else if (w.asleep)
                begin
                    elapsed = w.now - sleep_request_ms;
                    held_tier = (pol_ls_enable && elapsed >= pol_user_delay_ms) ?
                                TIER_LIGHT_SLEEP : TIER_SCREEN_OFF;
                end
                else
                begin
                    elapsed = w.now - last_activity_ms;
                    if (pol_ls_enable && elapsed >= pol_light_sleep_ms)
                        held_tier = TIER_LIGHT_SLEEP;
                    else if (elapsed >= pol_screen_off_ms)
                        held_tier = TIER_SCREEN_OFF;
                    else if (elapsed >= pol_dim_ms)
                        held_tier = TIER_DIM;
                    else
                        held_tier = TIER_ACTIVE;
                end
                held_changed = (held_tier != prev);
            end
            FUNC_ACTIVITY:
                last_activity_ms = w.now;
            FUNC_RESTART:
            begin
                held_tier = TIER_ACTIVE;
                held_changed = 1'b1;
                last_activity_ms = w.now;
                sleep_request_ms = w.now;
                prior_asleep = 1'b0;
            end
            default: ;
        endcase
        r.tier = held_tier;
        r.changed = held_changed;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // acceptance of input words: predict as each word is taken
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_tiers.push_back(next_tier_word('{func, now_ms, busy_req, user_asleep}));
            word_taken = 1'b1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            word_taken = 1'b0;
            if (drain_hold && expected_tiers.size() == 0)
                drain_hold = 1'b0;
            if (pending_words.size() != 0 && !drain_hold &&
                $urandom_range(99) >= send_idle_pct)
            begin
                next_word = pending_words.pop_front();
                func <= next_word.func;
                now_ms <= next_word.now;
                busy_req <= next_word.busy;
                user_asleep <= next_word.asleep;
                in_valid <= 1'b1;
                launched_count++;
                // let the pipe run dry now and then
                if (launched_count % DRAIN_EVERY == 0)
                    drain_hold = 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tiers.size() == 0)
                report_mismatch("result word with none expected", 32'({tier, changed}),
                                32'd0);
            else
            begin
                want_word = expected_tiers.pop_front();
                if (tier !== want_word.tier)
                    report_mismatch("tier", 32'(tier), 32'(want_word.tier));
                if (changed !== want_word.changed)
                    report_mismatch("changed", 32'(changed), 32'(want_word.changed));
            end
        end
    end

    task automatic push_word(func_t f, time_t t, logic b, logic a);
        pending_words.push_back('{f, t, b, a});
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_tiers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_LIGHT_SLEEP_ENABLE:   pol_ls_enable = v[0];
            CFG_DIM_AFTER_MS:         pol_dim_ms = v;
            CFG_SCREEN_OFF_AFTER_MS:  pol_screen_off_ms = v;
            CFG_LIGHT_SLEEP_AFTER_MS: pol_light_sleep_ms = v;
            CFG_USER_SLEEP_DELAY_MS:  pol_user_delay_ms = v;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_policy(logic [31:0] en, time_t dim, time_t scr, time_t light, time_t delay);
        wait_drained();
        write_reg(CFG_LIGHT_SLEEP_ENABLE, en);
        write_reg(CFG_DIM_AFTER_MS, dim);
        write_reg(CFG_SCREEN_OFF_AFTER_MS, scr);
        write_reg(CFG_LIGHT_SLEEP_AFTER_MS, light);
        write_reg(CFG_USER_SLEEP_DELAY_MS, delay);
        // out-of-range index must not disturb anything
        write_reg(CFG_UNUSED_INDEX, $urandom);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // mostly a running clock with sleep streaks, some restarts and raw noise
    task automatic random_words(int count, time_t step_max);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                push_word(func_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else
            begin
                clock_ms += ($urandom_range(99) < 2) ? $urandom : $urandom_range(step_max);
                if ($urandom_range(9) == 0)
                    asleep_now = ~asleep_now;
                if (roll < 6)
                    push_word(FUNC_RESTART, clock_ms, 1'($urandom_range(1)), asleep_now);
                else if (roll < 8)
                    push_word(FUNC_UNUSED, clock_ms, 1'($urandom_range(1)), asleep_now);
                else if (roll < 20)
                    push_word(FUNC_ACTIVITY, clock_ms, 1'($urandom_range(1)), asleep_now);
                else
                    push_word(FUNC_TICK, clock_ms, $urandom_range(9) == 0, asleep_now);
            end
        end
    endtask

    task automatic random_policy(logic [31:0] en, time_t scale, bit ordered);
        time_t dim;
        time_t scr;
        time_t light;
        dim = $urandom_range(scale);
        scr = ordered ? dim + $urandom_range(scale) : $urandom_range(scale);
        light = ordered ? scr + $urandom_range(2 * scale) : $urandom_range(2 * scale);
        set_policy(en, dim, scr, light, $urandom_range(2 * scale));
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset policy: walk the idle ladder, sleep request edges and wraps
        push_word(FUNC_ACTIVITY, 32'd0, 1'b0, 1'b0);
        push_word(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_word(FUNC_TICK, 32'd29999, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd30000, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd60000, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd299999, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd300000, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_word(FUNC_TICK, 32'd4998, 1'b0, 1'b1);
        push_word(FUNC_TICK, 32'd4999, 1'b0, 1'b1);
        push_word(FUNC_TICK, 32'd5000, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd5001, 1'b0, 1'b1);
        push_word(FUNC_ACTIVITY, 32'h8000_0000, 1'b1, 1'b0);
        push_word(FUNC_TICK, 32'h8000_0000, 1'b0, 1'b0);
        push_word(FUNC_RESTART, 32'h7FFF_FFFF, 1'b1, 1'b1);
        push_word(FUNC_TICK, 32'h8000_752F, 1'b0, 1'b0);
        push_word(FUNC_RESTART, 32'd0, 1'b0, 1'b0);
        clock_ms = '0;
        random_words(250, 32'd40000);

        // light sleep off, every threshold zero
        set_policy(32'd0, '0, '0, '0, '0);
        push_word(FUNC_TICK, 32'd0, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd1, 1'b0, 1'b1);
        push_word(FUNC_TICK, 32'd2, 1'b1, 1'b1);
        random_words(100, 32'd100);

        send_idle_pct = 86;
        recv_idle_pct = 20;
        // every threshold at its maximum
        set_policy(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(FUNC_RESTART, 32'd5, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd4, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd3, 1'b0, 1'b0);
        push_word(FUNC_TICK, 32'd7, 1'b0, 1'b1);
        push_word(FUNC_TICK, 32'd6, 1'b0, 1'b1);
        random_words(100, 32'hFFFF_FFFF);

        random_policy(32'd1, 32'd50, 1'b1);
        random_words(250, 32'd30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_policy(32'd0, 32'd200, 1'b0);
        random_words(150, 32'd60);
        random_policy(32'd1, 32'd1000, 1'b1);
        random_words(200, 32'd500);

        wait_drained();
        repeat (5) @(posedge clk);
        if (expected_tiers.size() != 0)
            report_mismatch("result words never seen", 32'd0, 32'(expected_tiers.size()));
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
